// ----- sv/positional_list_insert_delete_core_defines.svh -----
// Assertion macros for the positional list core.
`ifndef POSITIONAL_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/plid_pkg.sv -----
package plid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_DELETE   = 2'd1;
    localparam logic [1:0] KIND_TRAVERSE = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic [1:0]              status;
        logic                    last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

endpackage

// ----- sv/positional_list_insert_delete_core.sv -----
// Each command goes from the command queue through dispatch and its RAM steps to the
// result queue; insert shifts entries back, delete pulls them forward, traverse reads
// each entry in turn. The back end takes one item at a time; the entry RAM (one read or
// one write a cycle as used here, registered read) sets the pace; rejected items skip it.
// Reset (synchronous, active low) empties both queues and the list; RAM is not cleared.
module positional_list_insert_delete_core import plid_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  logic push,
    output logic full,
    output t_out o_result,
    output logic empty,
    input  logic pop
);

    t_cmd_link cmd_link;
    logic      cmd_pop;

    plid_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .push     (push),
        .full     (full),
        .o_cmd    (cmd_link),
        .i_cmd_pop(cmd_pop)
    );

    plid_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_link),
        .o_cmd_pop(cmd_pop),
        .o_result (o_result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

// ----- sv/plid_ram.sv -----
module plid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/plid_front.sv -----
`include "positional_list_insert_delete_core_defines.svh"

module plid_front import plid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in       i_item,
    input  logic      push,
    output logic      full,
    output t_cmd_link o_cmd,
    input  logic      i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       enq;
    logic       deq;
    t_cmd       cmd_in;

    assign full = (r_cnt == 2'd2);
    // unused kind is accepted and dropped here
    assign enq  = push && !full && (i_item.kind != KIND_NONE);
    assign deq  = i_cmd_pop && (r_cnt != 2'd0);

    always_comb begin
        cmd_in.op    = i_item.kind;
        cmd_in.pos   = i_item.position;
        cmd_in.value = i_item.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (enq) begin
                r_wp <= ~r_wp;
            end
            if (deq) begin
                r_rp <= ~r_rp;
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (deq && !enq) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.cmd   = r_q[r_rp];

    `ASSERT_NEXT(a_front_fill, i_clk, i_rst_n, enq && !deq, r_cnt == $past(r_cnt) + 2'd1)
    `ASSERT_IMPLIES(a_front_ptrs, i_clk, i_rst_n, r_cnt == 2'd1, r_wp != r_rp)
    `ASSERT_IMPLIES(a_front_ptrs_eq, i_clk, i_rst_n, r_cnt != 2'd1, r_wp == r_rp)

endmodule

// ----- sv/plid_back.sv -----
`include "positional_list_insert_delete_core_defines.svh"

module plid_back import plid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_link i_cmd,
    output logic      o_cmd_pop,
    output t_out      o_result,
    output logic      empty,
    input  logic      pop
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_INS_VAL  = 4'd4;
    localparam logic [3:0] S_DEL_RD0  = 4'd5;
    localparam logic [3:0] S_DEL_GONE = 4'd6;
    localparam logic [3:0] S_DEL_RD   = 4'd7;
    localparam logic [3:0] S_DEL_WR   = 4'd8;
    localparam logic [3:0] S_TRV_RD   = 4'd9;
    localparam logic [3:0] S_TRV_EMIT = 4'd10;
    localparam logic [3:0] S_RES      = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_occ, n_occ;
    t_cmd             r_cmd, n_cmd;
    t_out             r_res, n_res;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic [CMP_W-1:0] pos_m;
    logic [CMP_W-1:0] occ_m;
    logic [CMP_W-1:0] idx_m;
    logic             trv_last;

    t_out       r_rq [2];
    logic       r_rq_wp;
    logic       r_rq_rp;
    logic [1:0] r_rq_cnt;
    logic       rq_full;
    logic       rq_push;
    logic       rq_pop;
    t_out       rq_din;

    plid_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign pos_m    = CMP_W'(r_cmd.pos);
    assign occ_m    = CMP_W'(r_occ);
    assign idx_m    = CMP_W'(r_idx);
    assign trv_last = (idx_m + CMP_W'(1) == occ_m);
    assign rq_full  = (r_rq_cnt == 2'd2);
    assign rq_pop   = pop && !empty;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_occ     = r_occ;
        n_cmd     = r_cmd;
        n_res     = r_res;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_idx[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx[ADDR_W-1:0];
        rq_push   = 1'b0;
        rq_din    = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd.cmd;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (r_cmd.op)
                    KIND_INSERT: begin
                        if (pos_m == '0 || pos_m > occ_m + CMP_W'(1)) begin
                            n_res   = '{item_value: '0, status: ST_INVALID, last_of_run: 1'b1};
                            n_state = S_RES;
                        end else if (occ_m == CMP_W'(CAPACITY)) begin
                            n_res   = '{item_value: '0, status: ST_FULL, last_of_run: 1'b1};
                            n_state = S_RES;
                        end else begin
                            n_idx   = r_occ;
                            n_state = (pos_m == occ_m + CMP_W'(1)) ? S_INS_VAL : S_INS_RD;
                        end
                    end
                    KIND_DELETE: begin
                        if (pos_m == '0 || pos_m > occ_m) begin
                            n_res   = '{item_value: '0, status: ST_INVALID, last_of_run: 1'b1};
                            n_state = S_RES;
                        end else begin
                            n_idx   = CNT_W'(pos_m - CMP_W'(1));
                            n_state = S_DEL_RD0;
                        end
                    end
                    KIND_TRAVERSE: begin
                        if (r_occ == '0) begin
                            n_res   = '{item_value: '0, status: ST_EMPTY, last_of_run: 1'b1};
                            n_state = S_RES;
                        end else begin
                            n_idx   = '0;
                            n_state = S_TRV_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            // shift entries back one place, last first
            S_INS_RD: begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(idx_m - CMP_W'(1));
                n_state   = S_INS_WR;
            end
            S_INS_WR: begin
                ram_we  = 1'b1;
                n_idx   = r_idx - CNT_W'(1);
                n_state = (idx_m == pos_m) ? S_INS_VAL : S_INS_RD;
            end
            S_INS_VAL: begin
                ram_we    = 1'b1;
                ram_wdata = r_cmd.value;
                n_occ     = r_occ + CNT_W'(1);
                n_res     = '{item_value: r_cmd.value, status: ST_OK, last_of_run: 1'b1};
                n_state   = S_RES;
            end
            S_DEL_RD0: begin
                ram_re  = 1'b1;
                n_state = S_DEL_GONE;
            end
            S_DEL_GONE: begin
                n_res = '{item_value: ram_rdata, status: ST_OK, last_of_run: 1'b1};
                if (trv_last) begin
                    n_occ   = r_occ - CNT_W'(1);
                    n_state = S_RES;
                end else begin
                    n_state = S_DEL_RD;
                end
            end
            // pull later entries forward one place
            S_DEL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(idx_m + CMP_W'(1));
                n_state   = S_DEL_WR;
            end
            S_DEL_WR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + CNT_W'(1);
                if (idx_m + CMP_W'(2) == occ_m) begin
                    n_occ   = r_occ - CNT_W'(1);
                    n_state = S_RES;
                end else begin
                    n_state = S_DEL_RD;
                end
            end
            S_TRV_RD: begin
                ram_re  = 1'b1;
                n_state = S_TRV_EMIT;
            end
            S_TRV_EMIT: begin
                rq_din = '{item_value: ram_rdata, status: ST_OK, last_of_run: trv_last};
                if (!rq_full) begin
                    rq_push = 1'b1;
                    if (trv_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_TRV_RD;
                    end
                end
            end
            S_RES: begin
                if (!rq_full) begin
                    rq_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wp  <= 1'b0;
            r_rq_rp  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (rq_push) begin
                r_rq_wp <= ~r_rq_wp;
            end
            if (rq_pop) begin
                r_rq_rp <= ~r_rq_rp;
            end
            if (rq_push && !rq_pop) begin
                r_rq_cnt <= r_rq_cnt + 2'd1;
            end else if (rq_pop && !rq_push) begin
                r_rq_cnt <= r_rq_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rq_push) begin
            r_rq[r_rq_wp] <= rq_din;
        end
    end

    assign empty    = (r_rq_cnt == 2'd0);
    assign o_result = r_rq[r_rq_rp];

    `ASSERT_ALWAYS(a_occ_bound, i_clk, i_rst_n, occ_m <= CMP_W'(CAPACITY))
    `ASSERT_IMPLIES(a_wr_in_list, i_clk, i_rst_n, ram_we, CMP_W'(ram_waddr) <= occ_m)
    `ASSERT_IMPLIES(a_occ_step, i_clk, i_rst_n, n_occ != r_occ,
        r_state == S_INS_VAL || r_state == S_DEL_GONE || r_state == S_DEL_WR)
    `ASSERT_IMPLIES(a_pop_idle, i_clk, i_rst_n, o_cmd_pop, r_state == S_IDLE)

endmodule
